// ===== hw/rtl/lstmc_pkg.sv =====
// shared constants and activation functions for the lstm cell forward unit
package lstmc_pkg;

	localparam int IDX_W       = 12;
	localparam int Q_W         = 16;
	localparam int STORE_DEPTH = 1 << IDX_W;
	localparam int IN_TDATA_W  = 144;
	localparam int OUT_TDATA_W = 48;
	localparam int GATE_W      = 13;
	localparam int TANH_W      = 14;

	localparam logic [GATE_W-1:0] ONE_Q      = 13'd4096;
	localparam logic [16:0]       SIG_SAT_TH = 17'd20480;
	localparam logic [16:0]       SIG_HI_TH  = 17'd9728;
	localparam logic [16:0]       SIG_MID_TH = 17'd4096;
	localparam logic [GATE_W-1:0] SIG_HI_OFS  = 13'd3456;
	localparam logic [GATE_W-1:0] SIG_MID_OFS = 13'd2560;
	localparam logic [GATE_W-1:0] SIG_LO_OFS  = 13'd2048;
	localparam logic signed [31:0] Q24_HALF  = 32'sd2048;

	typedef logic signed [Q_W-1:0]    q_t;
	typedef logic [GATE_W-1:0]        gate_t;
	typedef logic signed [TANH_W-1:0] tanh_t;
	typedef logic [IDX_W-1:0]         idx_t;

	function automatic q_t sat16(input logic signed [31:0] v);
		q_t r;
		if (v > 32'sd32767)
			r = 16'sh7fff;
		else if (v < -32'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

	// piecewise-linear sigmoid, result in [0, 1.0]
	function automatic gate_t sigmoid_q(input logic signed [16:0] x);
		logic [16:0] a;
		gate_t y;
		a = x[16] ? 17'(-x) : 17'(x);
		if (a >= SIG_SAT_TH)
			y = ONE_Q;
		else if (a >= SIG_HI_TH)
			y = GATE_W'(a >> 5) + SIG_HI_OFS;
		else if (a >= SIG_MID_TH)
			y = GATE_W'(a >> 3) + SIG_MID_OFS;
		else
			y = GATE_W'(a >> 2) + SIG_LO_OFS;
		return x[16] ? ONE_Q - y : y;
	endfunction

	// tanh(x) = 2 * sigmoid(2x) - 1, the doubled argument kept at full width
	function automatic tanh_t tanh_q(input q_t x);
		gate_t s;
		logic signed [14:0] t;
		s = sigmoid_q({x, 1'b0});
		t = $signed({1'b0, s, 1'b0}) - 15'sd4096;
		return t[TANH_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/lstmc_ram.sv =====
// generic single write port ram with registered read
module lstmc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/lstm_cell_forward_unit.sv =====
// lstm cell forward unit: gate activations, cell update and hidden output
// an accepted request passes through the registered stages s1 to s8 before its result reaches the master side
// throughput: one request per cycle while the master side does not stall; a continuing request on the same unit as
//   the request directly ahead of it is held back by a bubble so that it sees that request's cell value
// reset: control clears at once, then a clearing pass zeroes the 4096-entry cell
//   store entry by entry with s_axis_tready low
module lstm_cell_forward_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// unit_index, in_gate_x, forget_gate_x, out_gate_x, cand_gate_x,
	// in_gate_h, forget_gate_h, out_gate_h, cand_gate_h, zero pad
	input  logic [lstmc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// cont
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// unit_index_out, hidden_out, cell_out, zero pad
	output logic [lstmc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import lstmc_pkg::*;

	// input fields
	idx_t in_idx;
	q_t   xi, xf, xo, xg, hi, hf, ho, hg;
	assign in_idx = s_axis_tdata[11:0];
	assign xi = s_axis_tdata[27:12];
	assign xf = s_axis_tdata[43:28];
	assign xo = s_axis_tdata[59:44];
	assign xg = s_axis_tdata[75:60];
	assign hi = s_axis_tdata[91:76];
	assign hf = s_axis_tdata[107:92];
	assign ho = s_axis_tdata[123:108];
	assign hg = s_axis_tdata[139:124];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic en1, en2, en3, en4, en5, en6, en7, en8;
	logic haz;
	logic clr_q;
	idx_t clr_addr_q;

	// stage payloads
	idx_t  idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6, idx_s7, idx_s8;
	logic  cont_s1, cont_s2, cont_s3;
	q_t    pi_s1, pf_s1, po_s1, pg_s1;
	gate_t gi_s2, gf_s2, go_s2, go_s3, go_s4, go_s5, go_s6;
	tanh_t gg_s2;
	gate_t gi_s3, gf_s3;
	tanh_t gg_s3;
	logic signed [29:0] prod_f_s4;
	logic signed [27:0] prod_i_s4;
	q_t    c_s5, c_s6, c_s7, c_s8;
	tanh_t th_s6;
	logic signed [27:0] prod_h_s7;
	q_t    h_s8;

	q_t    c_prev, c_new, rd_cell;
	logic signed [30:0] c_sum;
	logic signed [28:0] h_sum;
	idx_t  rd_addr;
	logic  ram_we;
	idx_t  ram_waddr;
	q_t    ram_wdata;

	// handshake chain
	assign haz = v_s3 && cont_s3 && v_s4 && (idx_s3 == idx_s4);
	assign en8 = !v_s8 || m_axis_tready;
	assign en7 = !v_s7 || en8;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = (!v_s3 || en4) && !haz;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_axis_tready = en1 && !clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			clr_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid && s_axis_tready;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3 && !haz;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == '1) begin
					clr_q <= 1'b0;
				end
			end
		end
	end

	// cell store read: address follows the request entering stage 3
	assign rd_addr = en3 ? idx_s2 : idx_s3;

	// value written two stages ahead has not reached the read port yet
	assign c_prev = (v_s5 && idx_s5 == idx_s3) ? c_s5 : rd_cell;

	assign c_sum = 31'(prod_f_s4) + 31'(prod_i_s4) + 31'(Q24_HALF);
	assign c_new = sat16(32'(c_sum >>> 12));
	assign h_sum = 29'(prod_h_s7) + 29'(Q24_HALF);

	assign ram_we    = clr_q || (v_s4 && en4);
	assign ram_waddr = clr_q ? clr_addr_q : idx_s4;
	assign ram_wdata = clr_q ? '0 : c_new;

	lstmc_ram #(
		.WIDTH(Q_W),
		.DEPTH(STORE_DEPTH)
	) u_cell_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr),
		.rdata(rd_cell)
	);

	always_ff @(posedge clk) begin
		if (en1) begin
			idx_s1  <= in_idx;
			cont_s1 <= s_axis_tuser;
			pi_s1 <= s_axis_tuser ? sat16(32'(xi) + 32'(hi)) : xi;
			pf_s1 <= s_axis_tuser ? sat16(32'(xf) + 32'(hf)) : xf;
			po_s1 <= s_axis_tuser ? sat16(32'(xo) + 32'(ho)) : xo;
			pg_s1 <= s_axis_tuser ? sat16(32'(xg) + 32'(hg)) : xg;
		end
		if (en2) begin
			idx_s2  <= idx_s1;
			cont_s2 <= cont_s1;
			gi_s2 <= sigmoid_q(17'(pi_s1));
			gf_s2 <= cont_s1 ? sigmoid_q(17'(pf_s1)) : '0;
			go_s2 <= sigmoid_q(17'(po_s1));
			gg_s2 <= tanh_q(pg_s1);
		end
		if (en3) begin
			idx_s3  <= idx_s2;
			cont_s3 <= cont_s2;
			gi_s3 <= gi_s2;
			gf_s3 <= gf_s2;
			go_s3 <= go_s2;
			gg_s3 <= gg_s2;
		end
		if (en4) begin
			idx_s4 <= idx_s3;
			go_s4  <= go_s3;
			prod_f_s4 <= $signed({1'b0, gf_s3}) * c_prev;
			prod_i_s4 <= $signed({1'b0, gi_s3}) * gg_s3;
		end
		if (en5) begin
			idx_s5 <= idx_s4;
			go_s5  <= go_s4;
			c_s5   <= c_new;
		end
		if (en6) begin
			idx_s6 <= idx_s5;
			go_s6  <= go_s5;
			c_s6   <= c_s5;
			th_s6  <= tanh_q(c_s5);
		end
		if (en7) begin
			idx_s7 <= idx_s6;
			c_s7   <= c_s6;
			prod_h_s7 <= $signed({1'b0, go_s6}) * th_s6;
		end
		if (en8) begin
			idx_s8 <= idx_s7;
			c_s8   <= c_s7;
			h_s8   <= sat16(32'(h_sum >>> 12));
		end
	end

	assign m_axis_tvalid = v_s8;
	assign m_axis_tdata  = {4'b0, c_s8, h_s8, idx_s8};

	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !s_axis_tready)
		else $error("request taken during cell store clearing");

	a_pipe_empty_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !(v_s1 || v_s4 || v_s8))
		else $error("pipeline holds data during clearing");

	a_haz_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(haz && en4) |=> (!v_s4 && v_s3))
		else $error("same-unit request not separated by a bubble");

	a_write_only_pipe_or_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (clr_q || v_s4))
		else $error("cell store written without a request in stage 4");

endmodule
